// File: design/olt_pkg.sv
// Shared constants, opcodes and map port types for the occluded line trace block.
// No dependencies; used by olt_map and occluded_line_trace.
`timescale 1ns / 1ps

package olt_pkg;

	// Coordinate width of every cell field on the ports
	localparam int CRD_W = 6;
	// Default grid edge length in cells
	localparam int GRID_SIZE_DEF = 64;
	// Scaled Bresenham error: holds 0 up to just under twice the major span
	localparam int ERR_W = CRD_W + 1;

	// Stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// Input item kinds carried on s_axis_tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	// Cell write request into the bitmap
	typedef struct packed {
		logic             en;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic             pass;
	} olt_wr_t;

	// Cell read address into the bitmap
	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
	} olt_rd_t;

endpackage

// File: design/occluded_line_trace.sv
// Operation: a write is taken in idle; a trace goes from idle through a setup state into the walk
// (one cell per cycle through the shared step unit and map port while the output is free).
// Throughput: one item at a time; a trace ends early when the walk is blocked.
// A full output register stalls the walk until the result is taken.
// Reset: arst_n clears control at once, then the bitmap is swept to impassable over all
// (GRID_SIZE rounded up to a power of two) squared entries (4096 by default) with no item taken.
`timescale 1ns / 1ps

module occluded_line_trace #(
	parameter int GRID_SIZE = olt_pkg::GRID_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], passable_bit[24], zero pad
	input  logic [olt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// opcode[0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// cell_x[5:0], cell_y[11:6], zero pad
	output logic [olt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// blocked[0]
	output logic                          m_axis_tuser,
	// last_cell
	output logic                          m_axis_tlast
);

	localparam int CRD_W = olt_pkg::CRD_W;
	localparam int ERR_W = olt_pkg::ERR_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]       state_q;

	// Latched trace endpoints
	logic [CRD_W-1:0] sx_q, sy_q, ex_q, ey_q;

	// Walk registers
	logic             ymaj_q;
	logic [CRD_W-1:0] m_q, n_q, m1_q;
	logic [CRD_W-1:0] span_q, nspan_q;
	logic             mup_q, nup_q;
	logic [ERR_W-1:0] err_q;

	// Output register
	logic             m_valid_q;
	logic [CRD_W-1:0] out_x_q, out_y_q;
	logic             out_blk_q, out_last_q;

	logic             s_acc;
	olt_pkg::olt_wr_t map_wr;
	olt_pkg::olt_rd_t map_rd;
	logic             cell_open;
	logic             clr_busy;

	logic [CRD_W-1:0] adx, ady;
	logic             ymaj_c;
	logic [CRD_W-1:0] m0_c, m1_c, n0_c, n1_c;

	logic [CRD_W-1:0] cur_x, cur_y;
	logic             slot_free;
	logic             walk_emit, walk_last, advance;
	logic signed [ERR_W:0] err_dec, err_sum;
	logic [ERR_W-1:0] err_nxt;
	logic [CRD_W-1:0] m_nxt, n_nxt;

	// Bitmap with its clearing sweep
	olt_map #(
		.GRID_SIZE(GRID_SIZE)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (map_wr),
		.rd      (map_rd),
		.rd_open (cell_open),
		.clr_busy(clr_busy)
	);

	// Input handshake and cell write request
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
		s_acc         = s_axis_tvalid && s_axis_tready;
		map_wr.en     = s_acc && (s_axis_tuser == olt_pkg::OP_WRITE);
		map_wr.x      = s_axis_tdata[5:0];
		map_wr.y      = s_axis_tdata[11:6];
		map_wr.pass   = s_axis_tdata[24];
	end

	// Setup: spans, major axis and step directions from the latched endpoints
	always_comb begin
		adx    = (ex_q > sx_q) ? ex_q - sx_q : sx_q - ex_q;
		ady    = (ey_q > sy_q) ? ey_q - sy_q : sy_q - ey_q;
		ymaj_c = (ady >= adx);
		m0_c   = ymaj_c ? sy_q : sx_q;
		m1_c   = ymaj_c ? ey_q : ex_q;
		n0_c   = ymaj_c ? sx_q : sy_q;
		n1_c   = ymaj_c ? ex_q : ey_q;
	end

	// Step unit: one cell per cycle while the output slot is free, scaled error update and next coordinates
	always_comb begin
		cur_x     = ymaj_q ? n_q : m_q;
		cur_y     = ymaj_q ? m_q : n_q;
		slot_free = !m_valid_q || m_axis_tready;
		walk_emit = (state_q == ST_WALK) && slot_free;
		walk_last = (m_q == m1_q) || !cell_open;
		advance   = walk_emit && !walk_last;

		err_dec = $signed({1'b0, err_q}) - $signed({1'b0, nspan_q, 1'b0});
		if (err_dec < 0) begin
			err_sum = err_dec + $signed({1'b0, span_q, 1'b0});
			n_nxt   = nup_q ? n_q + 1'b1 : n_q - 1'b1;
		end else begin
			err_sum = err_dec;
			n_nxt   = n_q;
		end
		err_nxt = err_sum[ERR_W-1:0];
		m_nxt   = mup_q ? m_q + 1'b1 : m_q - 1'b1;
	end

	// Map read address: start cell in setup, next cell when stepping, else hold
	always_comb begin
		if (state_q == ST_SETUP) begin
			map_rd.x = sx_q;
			map_rd.y = sy_q;
		end else if (advance) begin
			map_rd.x = ymaj_q ? n_nxt : m_nxt;
			map_rd.y = ymaj_q ? m_nxt : n_nxt;
		end else begin
			map_rd.x = cur_x;
			map_rd.y = cur_y;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_axis_tuser == olt_pkg::OP_TRACE)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_emit && walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch endpoints on an accepted transaction
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sx_q <= s_axis_tdata[5:0];
			sy_q <= s_axis_tdata[11:6];
			ex_q <= s_axis_tdata[17:12];
			ey_q <= s_axis_tdata[23:18];
		end
	end

	// Load walk registers in setup, advance them per emitted cell that is passable and not the end
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			ymaj_q  <= ymaj_c;
			m_q     <= m0_c;
			n_q     <= n0_c;
			m1_q    <= m1_c;
			span_q  <= ymaj_c ? ady : adx;
			nspan_q <= ymaj_c ? adx : ady;
			mup_q   <= (m0_c < m1_c);
			nup_q   <= (n0_c < n1_c);
			err_q   <= ERR_W'(ymaj_c ? ady : adx);
		end else if (advance) begin
			m_q   <= m_nxt;
			n_q   <= n_nxt;
			err_q <= err_nxt;
		end
	end

	// Output register: fill on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (walk_emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_emit) begin
			out_x_q    <= cur_x;
			out_y_q    <= cur_y;
			out_blk_q  <= !cell_open;
			out_last_q <= walk_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(olt_pkg::M_TDATA_W - 2 * CRD_W){1'b0}}, out_y_q, out_x_q};
	assign m_axis_tuser  = out_blk_q;
	assign m_axis_tlast  = out_last_q;

	// A trace transaction always goes through setup into the walk
	a_trace_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (s_axis_tuser == olt_pkg::OP_TRACE)) |=> (state_q == ST_SETUP))
		else $error("trace transaction did not enter setup");

	a_setup_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |=> (state_q == ST_WALK))
		else $error("setup did not enter walk");

	// The final cell closes the walk and is presented with tlast
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_emit && walk_last) |=> (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
		else $error("final cell did not end the walk");

	// No transaction is taken while the bitmap is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_axis_tready)
		else $error("input taken during bitmap clear");

	// Scaled error never exceeds twice the major span
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ({1'b0, err_q} <= {1'b0, span_q, 1'b0}))
		else $error("walk error out of range");

endmodule

// File: design/olt_map.sv
// Passability bitmap: one bit per cell, one write and one registered read a cycle.
// Sweeps every entry to impassable after reset. Depends on olt_pkg.
`timescale 1ns / 1ps

module olt_map #(
	parameter int GRID_SIZE = olt_pkg::GRID_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  olt_pkg::olt_wr_t wr,
	input  olt_pkg::olt_rd_t rd,
	output logic            rd_open,
	output logic            clr_busy
);

	localparam int CW    = $clog2(GRID_SIZE);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;

	logic          map_q [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;
	logic          rd_open_q;

	logic          wr_ok;
	logic          rd_ok;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	// Form addresses and flag cells that lie outside the grid
	always_comb begin
		wr_ok   = (int'(wr.x) < GRID_SIZE) && (int'(wr.y) < GRID_SIZE);
		rd_ok   = (int'(rd.x) < GRID_SIZE) && (int'(rd.y) < GRID_SIZE);
		wr_addr = {CW'(wr.y), CW'(wr.x)};
		rd_addr = {CW'(rd.y), CW'(rd.x)};
	end

	// Advance the clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == {AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Write port: sweep has priority, then cell writes inside the grid
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			map_q[clr_q] <= 1'b0;
		end else if (wr.en && wr_ok) begin
			map_q[wr_addr] <= wr.pass;
		end
	end

	// Registered read; cells outside the grid read as impassable
	always_ff @(posedge clk) begin
		rd_open_q <= map_q[rd_addr] & rd_ok;
	end

	assign rd_open  = rd_open_q;
	assign clr_busy = clr_busy_q;

endmodule
